// ----- design/multilevel_feedback_queue_scheduler_macros.svh -----
// assertion macros for the multilevel feedback queue scheduler checker
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfq checker: same-cycle property failed");

// next-cycle implication, disabled in reset
`define MFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfq checker: next-cycle property failed");

`endif

// ----- design/mfq_pkg.sv -----
// shared constants, types and helper functions of the feedback queue scheduler
package mfq_pkg;

  localparam int SLOTS     = 16;
  localparam int LEVELS    = 3;
  localparam int NQUEUES   = LEVELS + 1;
  localparam int BLOCKED_Q = LEVELS;
  localparam int SW        = $clog2(SLOTS);
  localparam int LW        = $clog2(SLOTS + 1);
  localparam int QW        = $clog2(NQUEUES);
  localparam int QCW       = $clog2(NQUEUES + 1);
  localparam int LVW       = $clog2(LEVELS);

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;

  localparam logic [1:0] LEVEL_CODE_BLOCKED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL       = 3'd5;

  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_OUTCOME  = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OC_REQUEUE   = 2'd0,
    OC_BLOCK     = 2'd1,
    OC_TERMINATE = 2'd2,
    OC_RESERVED  = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    KIND_ADMITTED   = 4'd0,
    KIND_REFUSED    = 4'd1,
    KIND_DISPATCHED = 4'd2,
    KIND_IDLE       = 4'd3,
    KIND_FINISHED   = 4'd4,
    KIND_REQUEUED   = 4'd5,
    KIND_BLOCKED    = 4'd6,
    KIND_FREED      = 4'd7,
    KIND_AGED       = 4'd8,
    KIND_UNBLOCKED  = 4'd9,
    KIND_TICK_DONE  = 4'd10
  } kind_t;

  typedef struct packed {
    logic [31:0] slice_one;
    logic [31:0] slice_two;
    logic [31:0] slice_three;
    logic [39:0] aging_two;
    logic [39:0] aging_three;
    logic [15:0] total;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  slot;
    logic        interactive;
    logic [1:0]  outcome;
    logic [31:0] time_ns;
    logic [39:0] block_ns;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [1:0]  level;
    logic [31:0] slice;
    logic        partial;
    logic [63:0] clock;
    logic        last;
  } res_t;

  function automatic logic [31:0] slice_of(input logic [7:0] lvl, input cfg_t c);
    if (lvl == 8'd0) return c.slice_one;
    if (lvl == 8'd1) return c.slice_two;
    return c.slice_three;
  endfunction

  function automatic logic [SW-1:0] slot_idx(input logic [3:0] s);
    logic [7:0] e;
    e = {4'd0, s};
    return e[SW-1:0];
  endfunction

  function automatic logic [3:0] slot_code(input logic [SW-1:0] s);
    logic [7:0] e;
    e = 8'(s);
    return e[3:0];
  endfunction

  function automatic logic slot_in_range(input logic [3:0] s);
    return {4'd0, s} < 8'(SLOTS);
  endfunction

  function automatic logic [1:0] level_code(input logic [7:0] lvl);
    return lvl[1:0];
  endfunction

  function automatic res_t make_res(input kind_t k, input logic [3:0] s,
                                    input logic [1:0] lvl, input logic [31:0] sl,
                                    input logic p, input logic [63:0] clk_v,
                                    input logic lst);
    res_t r;
    r.kind    = k;
    r.slot    = s;
    r.level   = lvl;
    r.slice   = sl;
    r.partial = p;
    r.clock   = clk_v;
    r.last    = lst;
    return r;
  endfunction

endpackage

// ----- design/mfq_front.sv -----
// front end: accepts stream transactions, decodes them into commands, two-entry queue
module mfq_front
  import mfq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       push;

  always_comb begin
    decoded.op          = op_t'(s_axis_tuser);
    decoded.slot        = s_axis_tdata[3:0];
    decoded.interactive = s_axis_tdata[4];
    decoded.outcome     = s_axis_tdata[6:5];
    decoded.time_ns     = s_axis_tdata[38:7];
    decoded.block_ns    = s_axis_tdata[78:39];
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (count != 2'd0);
  assign cmd           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= decoded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/mfq_back.sv -----
// back end: slot table, ready and blocked queues, clock, and result register
module mfq_back
  import mfq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [3:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_OUTC = 6'b000100,
    ST_FIND = 6'b001000,
    ST_TEST = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t      state;
  cmd_t        cmd_r;
  res_t        res;

  logic              busy        [SLOTS];
  logic              queued      [SLOTS];
  logic [QW-1:0]     qid         [SLOTS];
  logic [SW-1:0]     pos         [SLOTS];
  logic [LVW-1:0]    slot_level  [SLOTS];
  logic [63:0]       wait_start  [SLOTS];
  logic [63:0]       wake_time   [SLOTS];
  logic [LW-1:0]     qlen        [NQUEUES];
  logic [SW-1:0]     current_slot;
  logic [31:0]       current_slice;
  logic [63:0]       sched_clock;
  logic [15:0]       started_count;
  logic [15:0]       ended_count;
  logic [QCW-1:0]    scan_q;
  logic [LW-1:0]     scan_i;
  logic [SW-1:0]     found;
  logic              partial_r;

  logic              out_free;
  logic              out_load;
  logic              any_free;
  logic [SW-1:0]     free_slot;
  logic              any_ready;
  logic [QW-1:0]     disp_q;
  logic [SW-1:0]     head_slot;
  logic [SW-1:0]     find_slot;
  logic [SW-1:0]     cs;
  logic [31:0]       ref_slice;
  logic              outc_ok;
  logic [LVW-1:0]    adm_lvl;
  logic [LVW-1:0]    up_lvl;
  logic [QW-1:0]     sq;
  logic [63:0]       wait_diff;
  logic [63:0]       wake_diff;
  logic [63:0]       lim;
  logic              move_hit;
  logic [31:0]       disp_slice;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {1'b0, res.clock, res.partial, res.slice, res.level, res.slot};

  // a result register load this cycle
  always_comb begin
    case (state)
      ST_EXEC: out_load = out_free && (cmd_r.op == OP_ADMIT || cmd_r.op == OP_DISPATCH);
      ST_OUTC: out_load = out_free;
      ST_TEST: out_load = out_free && move_hit;
      ST_DONE: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        any_free  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    any_ready = 1'b0;
    disp_q    = '0;
    for (int q = LEVELS - 1; q >= 0; q--) begin
      if (qlen[q] != '0) begin
        any_ready = 1'b1;
        disp_q    = QW'(q);
      end
    end
  end

  assign sq = scan_q[QW-1:0];

  always_comb begin
    head_slot = '0;
    find_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (queued[i] && qid[i] == disp_q && pos[i] == '0) head_slot = SW'(i);
      if (queued[i] && qid[i] == sq && pos[i] == scan_i[SW-1:0]) find_slot = SW'(i);
    end
  end

  assign cs         = slot_idx(cmd_r.slot);
  assign ref_slice  = (cs == current_slot) ? current_slice
                                           : slice_of(8'(slot_level[cs]), cfg);
  assign outc_ok    = slot_in_range(cmd_r.slot) && busy[cs] && !queued[cs] &&
                      (cmd_r.outcome != OC_RESERVED);
  assign adm_lvl    = cmd_r.interactive ? LVW'(0) : LVW'(1);
  assign up_lvl     = (8'(slot_level[cs]) + 8'd1 < 8'(LEVELS)) ? slot_level[cs] + LVW'(1)
                                                               : slot_level[cs];
  assign disp_slice = slice_of(8'(disp_q), cfg);

  assign wait_diff = sched_clock - wait_start[found];
  assign wake_diff = sched_clock - wake_time[found];
  assign lim       = (scan_q == QCW'(1)) ? {24'd0, cfg.aging_two} : {24'd0, cfg.aging_three};
  assign move_hit  = (scan_q == QCW'(BLOCKED_Q)) ? !wake_diff[63] : (wait_diff >= lim);

  always_ff @(posedge clk) begin
    case (state)
      ST_EXEC: begin
        if (cmd_r.op == OP_ADMIT && out_free && any_free &&
            started_count < cfg.total) begin
          wait_start[free_slot] <= sched_clock;
        end
      end
      ST_OUTC: begin
        if (out_free) begin
          case (cmd_r.outcome)
            OC_REQUEUE: wait_start[cs] <= sched_clock;
            OC_BLOCK: begin
              wait_start[cs] <= sched_clock;
              wake_time[cs]  <= sched_clock + {24'd0, cmd_r.block_ns};
            end
            default: ;
          endcase
        end
      end
      ST_TEST: begin
        if (move_hit && out_free) wait_start[found] <= sched_clock;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        busy[i]       <= 1'b0;
        queued[i]     <= 1'b0;
        slot_level[i] <= '0;
      end
      for (int q = 0; q < NQUEUES; q++) qlen[q] <= '0;
      current_slot  <= '0;
      current_slice <= '0;
      sched_clock   <= '0;
      started_count <= '0;
      ended_count   <= '0;
      scan_q        <= '0;
      scan_i        <= '0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_r.op)
            OP_ADMIT: begin
              if (out_free) begin
                state <= ST_IDLE;
                if (started_count >= cfg.total || !any_free) begin
                  res <= make_res(KIND_REFUSED, 4'd0, 2'd0, 32'd0, 1'b0, sched_clock, 1'b1);
                end else begin
                  busy[free_slot]       <= 1'b1;
                  slot_level[free_slot] <= adm_lvl;
                  queued[free_slot]     <= 1'b1;
                  qid[free_slot]        <= QW'(adm_lvl);
                  pos[free_slot]        <= qlen[adm_lvl][SW-1:0];
                  qlen[adm_lvl]         <= qlen[adm_lvl] + LW'(1);
                  started_count         <= started_count + 16'd1;
                  res <= make_res(KIND_ADMITTED, slot_code(free_slot),
                                  level_code(8'(adm_lvl)), 32'd0, 1'b0, sched_clock, 1'b1);
                end
              end
            end
            OP_DISPATCH: begin
              if (out_free) begin
                state <= ST_IDLE;
                if (!any_ready) begin
                  if (qlen[BLOCKED_Q] == '0 && ended_count >= cfg.total)
                    res <= make_res(KIND_FINISHED, 4'd0, 2'd0, 32'd0, 1'b0, sched_clock, 1'b1);
                  else
                    res <= make_res(KIND_IDLE, 4'd0, 2'd0, 32'd0, 1'b0, sched_clock, 1'b1);
                end else begin
                  sched_clock <= sched_clock + {32'd0, cmd_r.time_ns};
                  for (int i = 0; i < SLOTS; i++) begin
                    if (queued[i] && qid[i] == disp_q && pos[i] != '0) pos[i] <= pos[i] - SW'(1);
                  end
                  queued[head_slot]     <= 1'b0;
                  qlen[disp_q]          <= qlen[disp_q] - LW'(1);
                  current_slot          <= head_slot;
                  current_slice         <= disp_slice;
                  slot_level[head_slot] <= LVW'(disp_q);
                  res <= make_res(KIND_DISPATCHED, slot_code(head_slot),
                                  level_code(8'(disp_q)), disp_slice, 1'b0,
                                  sched_clock + {32'd0, cmd_r.time_ns}, 1'b1);
                end
              end
            end
            OP_OUTCOME: begin
              if (outc_ok) begin
                sched_clock <= sched_clock + {32'd0, cmd_r.time_ns};
                partial_r   <= (cmd_r.time_ns != ref_slice);
                state       <= ST_OUTC;
              end else begin
                state <= ST_IDLE;
              end
            end
            default: begin
              sched_clock <= sched_clock + {32'd0, cmd_r.time_ns};
              scan_q      <= QCW'(1);
              scan_i      <= '0;
              state       <= ST_FIND;
            end
          endcase
        end
        ST_OUTC: begin
          if (out_free) begin
            state <= ST_IDLE;
            case (cmd_r.outcome)
              OC_REQUEUE: begin
                slot_level[cs] <= up_lvl;
                queued[cs]     <= 1'b1;
                qid[cs]        <= QW'(up_lvl);
                pos[cs]        <= qlen[up_lvl][SW-1:0];
                qlen[up_lvl]   <= qlen[up_lvl] + LW'(1);
                res <= make_res(KIND_REQUEUED, slot_code(cs), level_code(8'(up_lvl)),
                                32'd0, 1'b0, sched_clock, 1'b1);
              end
              OC_BLOCK: begin
                queued[cs]      <= 1'b1;
                qid[cs]         <= QW'(BLOCKED_Q);
                pos[cs]         <= qlen[BLOCKED_Q][SW-1:0];
                qlen[BLOCKED_Q] <= qlen[BLOCKED_Q] + LW'(1);
                res <= make_res(KIND_BLOCKED, slot_code(cs), LEVEL_CODE_BLOCKED,
                                32'd0, partial_r, sched_clock, 1'b1);
              end
              OC_TERMINATE: begin
                busy[cs]       <= 1'b0;
                slot_level[cs] <= '0;
                if (ended_count != 16'hFFFF) ended_count <= ended_count + 16'd1;
                res <= make_res(KIND_FREED, slot_code(cs), level_code(8'(slot_level[cs])),
                                32'd0, partial_r, sched_clock, 1'b1);
              end
              default: ;
            endcase
          end
        end
        ST_FIND: begin
          if (scan_q > QCW'(BLOCKED_Q)) begin
            state <= ST_DONE;
          end else if (scan_i >= qlen[sq]) begin
            scan_q <= scan_q + QCW'(1);
            scan_i <= '0;
          end else begin
            found <= find_slot;
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (!move_hit) begin
            scan_i <= scan_i + LW'(1);
            state  <= ST_FIND;
          end else if (out_free) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (queued[i] && qid[i] == sq && pos[i] > scan_i[SW-1:0])
                pos[i] <= pos[i] - SW'(1);
            end
            qlen[sq]          <= qlen[sq] - LW'(1);
            qid[found]        <= '0;
            pos[found]        <= qlen[0][SW-1:0];
            qlen[0]           <= qlen[0] + LW'(1);
            slot_level[found] <= '0;
            if (scan_q == QCW'(BLOCKED_Q))
              res <= make_res(KIND_UNBLOCKED, slot_code(found), LEVEL_CODE_BLOCKED,
                              32'd0, 1'b0, sched_clock, 1'b0);
            else
              res <= make_res(KIND_AGED, slot_code(found), level_code(8'(scan_q)),
                              32'd0, 1'b0, sched_clock, 1'b0);
            state <= ST_FIND;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res <= make_res(KIND_TICK_DONE, 4'd0, 2'd0, 32'd0, 1'b0, sched_clock, 1'b1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/multilevel_feedback_queue_scheduler.sv -----
// top level of the multilevel feedback queue scheduler: config registers, front and back
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser operation, tdata fields
//  m_axis    out  tvalid/tready, tlast      tuser kind, tdata fields
//  cfg       in   cfg_we                    cfg_index, cfg_data
//
// a tick looks at each entry in the lower and blocked queues (one entry per scan step, then
// a compare of its wait or wake time). up to two transactions wait in the front queue meanwhile.
// reset is synchronous and leaves all queues empty; no clearing pass is needed.
// a stalled result holds the back end; the front keeps accepting until its queue is full.
module multilevel_feedback_queue_scheduler
  import mfq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // slot, interactive, outcome, time_ns, block_ns, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot_out, level, slice_ns, partial_quantum, clock_now, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [3:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice_one   <= 32'd10000000;
      cfg.slice_two   <= 32'd20000000;
      cfg.slice_three <= 32'd40000000;
      cfg.aging_two   <= 40'd5000000000;
      cfg.aging_three <= 40'd10000000000;
      cfg.total       <= 16'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLICE_ONE:   cfg.slice_one   <= cfg_data[31:0];
        CFG_SLICE_TWO:   cfg.slice_two   <= cfg_data[31:0];
        CFG_SLICE_THREE: cfg.slice_three <= cfg_data[31:0];
        CFG_AGING_TWO:   cfg.aging_two   <= cfg_data;
        CFG_AGING_THREE: cfg.aging_three <= cfg_data;
        CFG_TOTAL:       cfg.total       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mfq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  mfq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- design/mfq_checker.sv -----
// port-level checker for the scheduler and its bind to the top level
`include "multilevel_feedback_queue_scheduler_macros.svh"

module mfq_checker
  import mfq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [3:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  // a waiting input transaction holds
  `MFQ_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
    s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))

  // a stalled result holds
  `MFQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // tick done always closes a transaction
  `MFQ_ASSERT_NOW(a_tick_last, m_axis_tvalid && m_axis_tuser == KIND_TICK_DONE, m_axis_tlast)

  // aged and unblocked results are never the final one
  `MFQ_ASSERT_NOW(a_scan_not_last,
    m_axis_tvalid && (m_axis_tuser == KIND_AGED || m_axis_tuser == KIND_UNBLOCKED),
    !m_axis_tlast)

  // only a dispatch grants a slice
  `MFQ_ASSERT_NOW(a_slice_zero, m_axis_tvalid && m_axis_tuser != KIND_DISPATCHED,
    m_axis_tdata[37:6] == 32'd0)

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);

// ----- bench/tb_multilevel_feedback_queue_scheduler.sv -----
// self-checking bench for the multilevel feedback queue scheduler
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler;
  import mfq_pkg::*;

  typedef struct {
    op_t         op;
    logic [3:0]  slot;
    logic        io;
    logic [1:0]  oc;
    logic [31:0] t;
    logic [39:0] blk;
    bit          typed;
    kind_t       kind;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [3:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  multilevel_feedback_queue_scheduler dut (.*);

  // scheduler state as predicted
  logic [31:0] sl_one, sl_two, sl_three;
  logic [39:0] age_two, age_three;
  logic [15:0] total_procs;
  int unsigned run_q[NQUEUES][$];
  bit          busy[SLOTS];
  bit          queued[SLOTS];
  int unsigned slot_lvl[SLOTS];
  logic [63:0] wake_at[SLOTS];
  logic [63:0] waiting_since[SLOTS];
  int unsigned cur_slot;
  logic [31:0] cur_slice;
  logic [63:0] sched_ns;
  int unsigned started, ended;

  res_t        pending_results[$];
  int          posted_count;
  int          fail_count;
  int          send_idle, recv_idle;
  bit          stall_request;
  bit          stall_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("multilevel_feedback_queue_scheduler test failed");
    $finish;
  end

  function automatic logic [31:0] level_slice(int unsigned lvl);
    if (lvl == 0) return sl_one;
    if (lvl == 1) return sl_two;
    return sl_three;
  endfunction

  function automatic void post(kind_t k, int unsigned s, int unsigned lvl, logic [31:0] sl,
                               logic p);
    res_t r;
    r.kind    = k;
    r.slot    = s[3:0];
    r.level   = lvl[1:0];
    r.slice   = sl;
    r.partial = p;
    r.clock   = sched_ns;
    r.last    = 1'b0;
    pending_results.push_back(r);
    posted_count++;
  endfunction

  function automatic void enqueue(int unsigned q, int unsigned s);
    run_q[q].push_back(s);
    waiting_since[s] = sched_ns;
    queued[s] = 1'b1;
  endfunction

  function automatic void schedule_step(op_t op, logic [3:0] s, logic io, logic [1:0] oc,
                                        logic [31:0] t, logic [39:0] blk);
    int          before_n;
    int unsigned q, i, e, lvl;
    logic [63:0] lim;
    logic [31:0] ref_slice;
    logic        part;
    before_n = pending_results.size();
    case (op)
      OP_ADMIT: begin
        e = SLOTS;
        for (i = 0; i < SLOTS; i++) if (!busy[i] && e == SLOTS) e = i;
        if (started >= total_procs || e == SLOTS) begin
          post(KIND_REFUSED, 0, 0, 0, 0);
        end else begin
          lvl = io ? 0 : 1;
          busy[e] = 1'b1;
          slot_lvl[e] = lvl;
          started = (started + 1) & 16'hFFFF;
          enqueue(lvl, e);
          post(KIND_ADMITTED, e, lvl, 0, 0);
        end
      end
      OP_DISPATCH: begin
        q = LEVELS;
        for (i = 0; i < LEVELS; i++) if (run_q[i].size() != 0 && q == LEVELS) q = i;
        if (q == LEVELS) begin
          if (run_q[BLOCKED_Q].size() == 0 && ended >= total_procs)
            post(KIND_FINISHED, 0, 0, 0, 0);
          else
            post(KIND_IDLE, 0, 0, 0, 0);
        end else begin
          sched_ns += 64'(t);
          e = run_q[q].pop_front();
          queued[e] = 1'b0;
          cur_slot = e;
          cur_slice = level_slice(q);
          slot_lvl[e] = q;
          post(KIND_DISPATCHED, e, q, cur_slice, 0);
        end
      end
      OP_OUTCOME: begin
        e = s;
        if (busy[e] && !queued[e] && oc != OC_RESERVED) begin
          ref_slice = (e == cur_slot) ? cur_slice : level_slice(slot_lvl[e]);
          part = (t != ref_slice);
          sched_ns += 64'(t);
          lvl = slot_lvl[e];
          if (oc == OC_REQUEUE) begin
            if (lvl + 1 < LEVELS) lvl++;
            slot_lvl[e] = lvl;
            enqueue(lvl, e);
            post(KIND_REQUEUED, e, lvl, 0, 0);
          end else if (oc == OC_BLOCK) begin
            wake_at[e] = sched_ns + 64'(blk);
            enqueue(BLOCKED_Q, e);
            post(KIND_BLOCKED, e, LEVEL_CODE_BLOCKED, 0, part);
          end else begin
            busy[e] = 1'b0;
            slot_lvl[e] = 0;
            if (ended < 16'hFFFF) ended++;
            post(KIND_FREED, e, lvl, 0, part);
          end
        end
      end
      default: begin
        sched_ns += 64'(t);
        for (q = 1; q < LEVELS; q++) begin
          lim = (q == 1) ? 64'(age_two) : 64'(age_three);
          i = 0;
          while (i < run_q[q].size()) begin
            e = run_q[q][i];
            if (sched_ns - waiting_since[e] >= lim) begin
              run_q[q].delete(i);
              slot_lvl[e] = 0;
              enqueue(0, e);
              post(KIND_AGED, e, q, 0, 0);
            end else begin
              i++;
            end
          end
        end
        i = 0;
        while (i < run_q[BLOCKED_Q].size()) begin
          e = run_q[BLOCKED_Q][i];
          if ($signed(sched_ns - wake_at[e]) >= 0) begin
            run_q[BLOCKED_Q].delete(i);
            slot_lvl[e] = 0;
            enqueue(0, e);
            post(KIND_UNBLOCKED, e, LEVEL_CODE_BLOCKED, 0, 0);
          end else begin
            i++;
          end
        end
        post(KIND_TICK_DONE, 0, 0, 0, 0);
      end
    endcase
    if (pending_results.size() > before_n) pending_results[$].last = 1'b1;
  endfunction

  task automatic offer(op_t op, logic [3:0] s, logic io, logic [1:0] oc, logic [31:0] t,
                       logic [39:0] blk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, blk, t, oc, io, s};
    do @(posedge clk); while (!s_axis_tready);
    schedule_step(op, s, io, oc, t, blk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SLICE_ONE:   sl_one = val[31:0];
      CFG_SLICE_TWO:   sl_two = val[31:0];
      CFG_SLICE_THREE: sl_three = val[31:0];
      CFG_AGING_TWO:   age_two = val;
      CFG_AGING_THREE: age_three = val;
      default:         total_procs = val[15:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all results, then give ignored transactions time to clear the pipeline
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(negedge clk);
  endtask

  task automatic load_config(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [39:0] d,
                             logic [39:0] e, logic [15:0] n);
    drain();
    write_reg(CFG_SLICE_ONE, 40'(a));
    write_reg(CFG_SLICE_TWO, 40'(b));
    write_reg(CFG_SLICE_THREE, 40'(c));
    write_reg(CFG_AGING_TWO, d);
    write_reg(CFG_AGING_THREE, e);
    write_reg(CFG_TOTAL, 40'(n));
  endtask

  task automatic random_items(int n);
    op_t         op;
    logic [3:0]  s;
    logic [1:0]  oc;
    logic [31:0] t;
    logic [39:0] blk;
    int unsigned r, k;
    repeat (n) begin
      r = $urandom_range(0, 99);
      op = (r < 25) ? OP_ADMIT : (r < 50) ? OP_DISPATCH : (r < 80) ? OP_OUTCOME : OP_TICK;
      t = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 2000));
      blk = ($urandom_range(0, 7) == 0) ? {8'($urandom), 32'($urandom)}
                                        : 40'($urandom_range(0, 4000));
      oc = ($urandom_range(0, 19) == 0) ? OC_RESERVED : 2'($urandom_range(0, 2));
      s = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 6) begin
        s = cur_slot[3:0];
      end else if (r < 9) begin
        for (k = 0; k < SLOTS; k++) if (busy[k] && !queued[k]) s = k[3:0];
      end
      if (op == OP_OUTCOME && $urandom_range(0, 9) < 4)
        t = (s == cur_slot) ? cur_slice : level_slice(slot_lvl[s]);
      offer(op, s, 1'($urandom_range(0, 1)), oc, t, blk);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d tdata %h", $time, m_axis_tuser,
                 m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.kind || m_axis_tdata[3:0] != want.slot ||
            m_axis_tdata[5:4] != want.level || m_axis_tdata[37:6] != want.slice ||
            m_axis_tdata[38] != want.partial || m_axis_tdata[102:39] != want.clock ||
            m_axis_tlast != want.last) begin
          $display("%0t: expected kind %0d slot %0d level %0d slice %0d partial %0b clock %0d last %0b",
                   $time, want.kind, want.slot, want.level, want.slice, want.partial,
                   want.clock, want.last);
          $display("%0t: actual   kind %0d slot %0d level %0d slice %0d partial %0b clock %0d last %0b",
                   $time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[5:4],
                   m_axis_tdata[37:6], m_axis_tdata[38], m_axis_tdata[102:39], m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int        before_n;
    fail_count = 0;
    posted_count = 0;
    stall_request = 1'b0;
    send_idle = 35;
    recv_idle = 77;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADMIT;
    cfg_we = 1'b0;
    cfg_index = CFG_SLICE_ONE;
    cfg_data = '0;
    sl_one = 32'd10000000;
    sl_two = 32'd20000000;
    sl_three = 32'd40000000;
    age_two = 40'd5000000000;
    age_three = 40'd10000000000;
    total_procs = 16'd50;
    foreach (busy[i]) begin
      busy[i] = 1'b0;
      queued[i] = 1'b0;
      slot_lvl[i] = 0;
      wake_at[i] = '0;
      waiting_since[i] = '0;
    end
    cur_slot = 0;
    cur_slice = '0;
    sched_ns = '0;
    started = 0;
    ended = 0;

    rows = '{
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 5, 0, 1, KIND_IDLE},
      '{OP_TICK, 0, 0, OC_REQUEUE, 0, 0, 1, KIND_TICK_DONE},
      '{OP_ADMIT, 0, 1, OC_REQUEUE, 0, 0, 1, KIND_ADMITTED},
      '{OP_ADMIT, 0, 0, OC_REQUEUE, 0, 0, 1, KIND_ADMITTED},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 32'hFFFFFFFF, 0, 1, KIND_DISPATCHED},
      '{OP_OUTCOME, 0, 0, OC_REQUEUE, 10000000, 0, 1, KIND_REQUEUED},
      '{OP_OUTCOME, 0, 0, OC_BLOCK, 7, 7, 0, KIND_IDLE},
      '{OP_OUTCOME, 15, 1, OC_TERMINATE, 7, 7, 0, KIND_IDLE},
      '{OP_OUTCOME, 1, 0, OC_RESERVED, 7, 7, 0, KIND_IDLE},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 3, 0, 1, KIND_DISPATCHED},
      '{OP_OUTCOME, 1, 0, OC_BLOCK, 1, 40'hFFFFFFFFFF, 1, KIND_BLOCKED},
      '{OP_OUTCOME, 1, 0, OC_RESERVED, 1, 0, 0, KIND_IDLE},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 0, 0, 1, KIND_DISPATCHED},
      '{OP_OUTCOME, 0, 0, OC_TERMINATE, 0, 0, 1, KIND_FREED},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 0, 0, 1, KIND_IDLE},
      '{OP_ADMIT, 0, 0, OC_REQUEUE, 0, 0, 1, KIND_ADMITTED},
      '{OP_ADMIT, 0, 1, OC_REQUEUE, 0, 0, 1, KIND_ADMITTED},
      '{OP_TICK, 0, 0, OC_REQUEUE, 32'hFFFFFFFF, 0, 0, KIND_IDLE},
      '{OP_TICK, 0, 0, OC_REQUEUE, 32'hFFFFFFFF, 0, 0, KIND_IDLE},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 32'h80000000, 0, 1, KIND_DISPATCHED},
      '{OP_OUTCOME, 0, 1, OC_REQUEUE, 20000000, 40'h5555555555, 0, KIND_IDLE},
      '{OP_DISPATCH, 0, 0, OC_REQUEUE, 1, 0, 0, KIND_IDLE},
      '{OP_OUTCOME, 2, 0, OC_BLOCK, 40000000, 40'hAAAAAAAAAA, 0, KIND_IDLE},
      '{OP_TICK, 0, 0, OC_REQUEUE, 32'h7FFFFFFF, 0, 0, KIND_IDLE}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      before_n = posted_count;
      offer(rows[i].op, rows[i].slot, rows[i].io, rows[i].oc, rows[i].t, rows[i].blk);
      if (rows[i].typed && (posted_count == before_n ||
                            pending_results[$].kind != rows[i].kind)) begin
        $display("%0t: row %0d expected kind %0d, actual prediction differs", $time, i,
                 rows[i].kind);
        fail_count++;
      end
    end

    load_config(32'd300, 32'd700, 32'd1500, 40'd1000, 40'd3000, 16'd65535);
    random_items(110);

    send_idle = 77;
    recv_idle = 35;
    load_config(32'd0, 32'd0, 32'd0, 40'd0, 40'd0, 16'd2);
    random_items(70);
    load_config(32'd1000, 32'd1000, 32'd1000, 40'd2500, 40'd500, 16'd0);
    random_items(20);

    send_idle = 0;
    recv_idle = 0;
    load_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF,
                16'd65535);
    stall_request = 1'b1;
    random_items(90);

    drain();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("multilevel_feedback_queue_scheduler test passed");
    end else begin
      $display("multilevel_feedback_queue_scheduler test failed");
    end
    $finish;
  end

endmodule
